@@ rtl/kest_pkg.sv @@
`default_nettype none

package kest_pkg;

    localparam int LIGHTS = 32;
    localparam int AW     = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;
    localparam int IW     = AW + 1;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_DECAY = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] HOW_KEY      = 2'd0;
    localparam logic [1:0] HOW_EXPIRED  = 2'd1;
    localparam logic [1:0] HOW_FALLBACK = 2'd2;
    localparam logic [1:0] HOW_NONE     = 2'd3;

    typedef struct packed {
        logic [15:0]        key;
        logic [31:0]        expiry;
        logic signed [15:0] radius;
        logic [15:0]        decay;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_EXP,
        ST_ALLOC,
        ST_DECAY,
        ST_RDADDR,
        ST_RDDATA,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

@@ rtl/keyed_expiring_slot_table_top.sv @@
`default_nettype none

// Keyed expiring slot table.
// Input channel (i_valid / o_ready) carries one operation per transaction:
// allocate a slot, apply a decay tick to all slots, or read one slot.
// Output channel (o_valid / i_ready) returns exactly one result transaction
// per input transaction, in order.
// One operation is worked at a time; o_ready is high only while idle.
// Work per operation, from input acceptance to o_valid:
//   allocate with nonzero key: key scan, then expiry scan if no key
//   matches, one slot read per cycle from the single table read port,
//   ending early when a scan hits;
//   allocate with key 0: expiry scan only;
//   decay tick: one pass over all slots (read, multiply, write back per slot);
//   read or unused op: one table read; read out of range: no table read.
// After the result handshake the block passes through idle, where it takes
// the next transaction.
// Reset clears the per-slot valid flags at once, so every slot reads as zero
// without a clearing pass; the block is ready in the first cycle after reset.
// When the receiver stalls, the result is held and no new input is taken.

module keyed_expiring_slot_table_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_key,
    input  wire logic [4:0]  i_slot_index,
    input  wire logic [31:0] i_now_time,
    input  wire logic [15:0] i_elapsed,
    input  wire logic signed [15:0] i_new_radius,
    input  wire logic [15:0] i_new_decay,
    input  wire logic [31:0] i_new_expiry,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [4:0]       o_slot,
    output logic [1:0]       o_how_chosen,
    output logic [15:0]      o_slot_key,
    output logic signed [15:0] o_slot_radius,
    output logic [31:0]      o_slot_expiry
);

    import kest_pkg::*;

    t_state r_state, n_state;

    // latched transaction
    logic [15:0]        r_key;
    logic [31:0]        r_now;
    logic [15:0]        r_elapsed;
    logic signed [15:0] r_nrad;
    logic [15:0]        r_ndec;
    logic [31:0]        r_nexp;
    logic [AW-1:0]      r_ridx;

    // scan pipeline
    logic [IW-1:0]      r_idx;
    logic               r_chk;
    logic [AW-1:0]      r_cidx;
    logic               r_wv;
    logic [AW-1:0]      r_widx;
    t_entry             r_went;
    logic [31:0]        r_amt;
    logic [AW-1:0]      r_pick;

    logic [LIGHTS-1:0]  r_valid;
    logic               r_rd_vld;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_entry             ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [EW-1:0]      ram_rdata;
    t_entry             ent;

    logic               in_acc;
    logic               issuing;
    logic               scan_done;
    logic               key_hit;
    logic               exp_hit;
    logic               decay_live;
    logic               rd_in_range;
    logic [16:0]        mag;
    logic               sat;
    logic signed [15:0] dec_rad;

    kest_ram #(
        .WIDTH(EW),
        .DEPTH(LIGHTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // a slot never written since reset reads as all zero
    assign ent         = r_rd_vld ? t_entry'(ram_rdata) : '0;
    assign in_acc      = i_valid && o_ready;
    assign issuing     = (r_idx < IW'(LIGHTS));
    assign scan_done   = !issuing && !r_chk && !r_wv;
    assign key_hit     = r_chk && (ent.key == r_key);
    assign exp_hit     = r_chk && (ent.expiry < r_now);
    assign decay_live  = r_chk && !(ent.expiry < r_now) && (ent.radius != 16'sd0);
    assign rd_in_range = (32'(i_slot_index) < 32'(LIGHTS));

    // saturating move of radius toward zero
    assign mag     = r_went.radius[15] ? (17'd0 - {1'b1, r_went.radius})
                                       : {1'b0, r_went.radius};
    assign sat     = (r_amt >= 32'(mag));
    assign dec_rad = sat ? 16'sd0
                   : (r_went.radius[15] ? (r_went.radius + signed'(r_amt[15:0]))
                                        : (r_went.radius - signed'(r_amt[15:0])));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_op)
                        OP_ALLOC: n_state = (i_key != 16'd0) ? ST_KEY : ST_EXP;
                        OP_DECAY: n_state = ST_DECAY;
                        OP_READ:  n_state = rd_in_range ? ST_RDADDR : ST_OUT;
                        default:  n_state = ST_RDADDR;
                    endcase
                end
            end
            ST_KEY: begin
                if (key_hit) begin
                    n_state = ST_ALLOC;
                end else if (scan_done) begin
                    n_state = ST_EXP;
                end
            end
            ST_EXP: begin
                if (exp_hit || scan_done) begin
                    n_state = ST_ALLOC;
                end
            end
            ST_ALLOC:  n_state = ST_OUT;
            ST_DECAY: begin
                if (scan_done) begin
                    n_state = ST_RDADDR;
                end
            end
            ST_RDADDR: n_state = ST_RDDATA;
            ST_RDDATA: n_state = ST_OUT;
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs and table port control
    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_widx;
        ram_wdata = r_went;
        ram_raddr = r_idx[AW-1:0];
        case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_ALLOC: begin
                ram_we    = 1'b1;
                ram_waddr = r_pick;
                ram_wdata = '{key: r_key, expiry: r_nexp, radius: r_nrad, decay: r_ndec};
            end
            ST_DECAY: begin
                ram_we           = r_wv;
                ram_wdata.radius = dec_rad;
            end
            ST_RDADDR: ram_raddr = r_ridx;
            ST_OUT:    o_valid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_idx   <= '0;
            r_chk   <= 1'b0;
            r_wv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (in_acc || ((r_state == ST_KEY) && scan_done)) begin
                r_idx <= '0;
                r_chk <= 1'b0;
                r_wv  <= 1'b0;
            end else if ((r_state == ST_KEY) || (r_state == ST_EXP)
                         || (r_state == ST_DECAY)) begin
                // advance the read pointer, hold it at the end
                if (issuing) begin
                    r_idx <= r_idx + IW'(1);
                end
                r_chk <= issuing;
                r_wv  <= (r_state == ST_DECAY) && decay_live;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[ram_raddr];
        r_cidx   <= r_idx[AW-1:0];
        r_widx   <= r_cidx;
        r_went   <= ent;
        r_amt    <= 32'(r_elapsed) * 32'(ent.decay);

        if (in_acc) begin
            r_key        <= i_key;
            r_now        <= i_now_time;
            r_elapsed    <= i_elapsed;
            r_nrad       <= i_new_radius;
            r_ndec       <= i_new_decay;
            r_nexp       <= i_new_expiry;
            r_ridx       <= (i_op == OP_READ) ? AW'(i_slot_index) : '0;
            o_slot       <= (i_op == OP_READ) ? i_slot_index : 5'd0;
            o_how_chosen <= HOW_NONE;
            // out-of-range read reports zeros at once
            o_slot_key    <= 16'd0;
            o_slot_radius <= 16'sd0;
            o_slot_expiry <= 32'd0;
        end

        case (r_state)
            ST_KEY: begin
                if (key_hit) begin
                    r_pick       <= r_cidx;
                    o_how_chosen <= HOW_KEY;
                end
            end
            ST_EXP: begin
                if (exp_hit) begin
                    r_pick       <= r_cidx;
                    o_how_chosen <= HOW_EXPIRED;
                end else if (scan_done) begin
                    r_pick       <= '0;
                    o_how_chosen <= HOW_FALLBACK;
                end
            end
            ST_ALLOC: begin
                o_slot        <= 5'(r_pick);
                o_slot_key    <= r_key;
                o_slot_radius <= r_nrad;
                o_slot_expiry <= r_nexp;
            end
            ST_RDDATA: begin
                o_slot_key    <= ent.key;
                o_slot_radius <= ent.radius;
                o_slot_expiry <= ent.expiry;
            end
            default: begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while a result is pending");

    a_alloc_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ALLOC) |=> o_valid)
        else $error("allocate write not followed by its result");

    a_out_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> o_ready)
        else $error("not ready after result transaction");

    a_key_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_how_chosen == HOW_KEY)) |-> (o_slot_key != 16'd0))
        else $error("key match reported with zero key");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (32'(ram_waddr) < 32'(LIGHTS)))
        else $error("table write beyond last slot");
`endif

endmodule

`default_nettype wire

@@ rtl/kest_ram.sv @@
`default_nettype none

module kest_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import kest_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        key;
        logic [4:0]         slot_index;
        logic [31:0]        now_time;
        logic [15:0]        elapsed;
        logic signed [15:0] new_radius;
        logic [15:0]        new_decay;
        logic [31:0]        new_expiry;
    } t_light_cmd;

    typedef struct packed {
        logic [4:0]         slot;
        logic [1:0]         how;
        logic [15:0]        key;
        logic signed [15:0] radius;
        logic [31:0]        expiry;
    } t_slot_report;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               i_ready      = 1'b0;
    logic [1:0]         i_op         = OP_READ;
    logic [15:0]        i_key        = '0;
    logic [4:0]         i_slot_index = '0;
    logic [31:0]        i_now_time   = '0;
    logic [15:0]        i_elapsed    = '0;
    logic signed [15:0] i_new_radius = '0;
    logic [15:0]        i_new_decay  = '0;
    logic [31:0]        i_new_expiry = '0;

    logic               o_ready;
    logic               o_valid;
    logic [4:0]         o_slot;
    logic [1:0]         o_how_chosen;
    logic [15:0]        o_slot_key;
    logic signed [15:0] o_slot_radius;
    logic [31:0]        o_slot_expiry;

    keyed_expiring_slot_table_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_key        (i_key),
        .i_slot_index (i_slot_index),
        .i_now_time   (i_now_time),
        .i_elapsed    (i_elapsed),
        .i_new_radius (i_new_radius),
        .i_new_decay  (i_new_decay),
        .i_new_expiry (i_new_expiry),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_slot       (o_slot),
        .o_how_chosen (o_how_chosen),
        .o_slot_key   (o_slot_key),
        .o_slot_radius(o_slot_radius),
        .o_slot_expiry(o_slot_expiry)
    );

    // Shadow copy of the slot table, cleared like the block at reset.
    logic [15:0]        tbl_key    [LIGHTS];
    logic [31:0]        tbl_expiry [LIGHTS];
    logic signed [15:0] tbl_radius [LIGHTS];
    logic [15:0]        tbl_decay  [LIGHTS];

    t_slot_report slot_reports_due[$];
    int           fail_count   = 0;
    int           cycle_count  = 0;
    bit           calm         = 1'b0;
    bit           hold_request = 1'b0;
    int           hold_left    = 0;
    logic [31:0]  epoch        = '0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Result side: random stalls, quiet stretches and a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 29);
        end
    end

    always @(posedge i_clk) begin
        t_slot_report want;
        if (i_rst_n && o_valid && i_ready) begin
            if (slot_reports_due.size() == 0) begin
                $error("unexpected result transaction: slot %0d", o_slot);
                fail_count++;
            end else begin
                want = slot_reports_due.pop_front();
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_slot);
                    fail_count++;
                end
                if (o_how_chosen !== want.how) begin
                    $error("how_chosen: expected %0d, got %0d", want.how, o_how_chosen);
                    fail_count++;
                end
                if (o_slot_key !== want.key) begin
                    $error("slot_key: expected %h, got %h", want.key, o_slot_key);
                    fail_count++;
                end
                if (o_slot_radius !== want.radius) begin
                    $error("slot_radius: expected %0d, got %0d", want.radius, o_slot_radius);
                    fail_count++;
                end
                if (o_slot_expiry !== want.expiry) begin
                    $error("slot_expiry: expected %h, got %h", want.expiry, o_slot_expiry);
                    fail_count++;
                end
            end
        end
    end

    function automatic t_slot_report report_of(input int s, input logic [1:0] how);
        t_slot_report rep;
        rep.slot   = s[4:0];
        rep.how    = how;
        rep.key    = tbl_key[s];
        rep.radius = tbl_radius[s];
        rep.expiry = tbl_expiry[s];
        return rep;
    endfunction

    // Apply one operation to the shadow table and return the slot report it yields.
    function automatic t_slot_report apply_light_op(input t_light_cmd c);
        int           pick;
        logic [1:0]   how;
        bit           found;
        longint       r;
        longint       amt;
        t_slot_report rep;
        pick  = 0;
        how   = HOW_FALLBACK;
        found = 1'b0;
        case (c.op)
            OP_ALLOC: begin
                if (c.key != 0) begin
                    for (int i = 0; i < LIGHTS; i++) begin
                        if (!found && tbl_key[i] == c.key) begin
                            pick  = i;
                            how   = HOW_KEY;
                            found = 1'b1;
                        end
                    end
                end
                for (int i = 0; i < LIGHTS; i++) begin
                    if (!found && tbl_expiry[i] < c.now_time) begin
                        pick  = i;
                        how   = HOW_EXPIRED;
                        found = 1'b1;
                    end
                end
                tbl_key[pick]    = c.key;
                tbl_radius[pick] = c.new_radius;
                tbl_decay[pick]  = c.new_decay;
                tbl_expiry[pick] = c.new_expiry;
                rep = report_of(pick, how);
            end
            OP_DECAY: begin
                for (int i = 0; i < LIGHTS; i++) begin
                    r = tbl_radius[i];
                    if (!(tbl_expiry[i] < c.now_time) && r != 0) begin
                        amt = longint'(c.elapsed) * longint'(tbl_decay[i]);
                        // move toward zero, never past it
                        if (r > 0) r = (r > amt) ? r - amt : 0;
                        else r = (-r > amt) ? r + amt : 0;
                        tbl_radius[i] = r[15:0];
                    end
                end
                rep = report_of(0, HOW_NONE);
            end
            OP_READ: begin
                if (int'(c.slot_index) < LIGHTS) begin
                    rep = report_of(int'(c.slot_index), HOW_NONE);
                end else begin
                    rep      = '0;
                    rep.slot = c.slot_index;
                    rep.how  = HOW_NONE;
                end
            end
            default: rep = report_of(0, HOW_NONE);
        endcase
        return rep;
    endfunction

    function automatic t_light_cmd light_cmd(input logic [1:0] op, input logic [15:0] key,
                                             input logic [4:0] idx, input logic [31:0] now,
                                             input logic [15:0] elapsed,
                                             input logic [15:0] radius,
                                             input logic [15:0] decay,
                                             input logic [31:0] expiry);
        t_light_cmd c;
        c.op         = op;
        c.key        = key;
        c.slot_index = idx;
        c.now_time   = now;
        c.elapsed    = elapsed;
        c.new_radius = radius;
        c.new_decay  = decay;
        c.new_expiry = expiry;
        return c;
    endfunction

    // Mostly coherent traffic around a slowly advancing clock, with some raw noise.
    function automatic t_light_cmd random_light_cmd();
        t_light_cmd c;
        int         sel;
        int         kroll;
        if ($urandom_range(99) < 15) begin
            c.op         = 2'($urandom_range(3));
            c.key        = 16'($urandom);
            c.slot_index = 5'($urandom);
            c.now_time   = $urandom;
            c.elapsed    = 16'($urandom);
            c.new_radius = 16'($urandom);
            c.new_decay  = 16'($urandom);
            c.new_expiry = $urandom;
            return c;
        end
        epoch = epoch + $urandom_range(40);
        sel   = $urandom_range(99);
        kroll = $urandom_range(99);
        if (sel < 50) c.op = OP_ALLOC;
        else if (sel < 70) c.op = OP_DECAY;
        else if (sel < 94) c.op = OP_READ;
        else c.op = OP_UNUSED;
        if (kroll < 10) c.key = '0;
        else if (kroll < 90) c.key = 16'($urandom_range(1, 48));
        else c.key = 16'($urandom);
        c.slot_index = 5'($urandom_range(31));
        // a zero time expires nothing, which leads to the fallback slot unless the key matches
        c.now_time   = ($urandom_range(99) < 4) ? 32'd0 : epoch;
        c.elapsed    = ($urandom_range(99) < 85) ? 16'($urandom_range(20)) : 16'($urandom);
        c.new_radius = 16'($urandom);
        c.new_decay  = ($urandom_range(99) < 80) ? 16'($urandom_range(50)) : 16'($urandom);
        c.new_expiry = epoch + $urandom_range(600);
        return c;
    endfunction

    task automatic send_light_cmd(input t_light_cmd c);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 29) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_op         <= c.op;
        i_key        <= c.key;
        i_slot_index <= c.slot_index;
        i_now_time   <= c.now_time;
        i_elapsed    <= c.elapsed;
        i_new_radius <= c.new_radius;
        i_new_decay  <= c.new_decay;
        i_new_expiry <= c.new_expiry;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        slot_reports_due.push_back(apply_light_op(c));
    endtask

    task automatic wait_for_reports();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (slot_reports_due.size() != 0);
    endtask

    task automatic test_directed_cases();
        send_light_cmd(light_cmd(OP_READ,  16'h0000, 5'd0,  32'd0, 16'd0, 16'h0000, 16'h0000,
                                 32'd0));
        send_light_cmd(light_cmd(OP_READ,  16'h0000, 5'd31, 32'd0, 16'd0, 16'h0000, 16'h0000,
                                 32'd0));
        // nothing expired at time zero: fallback slot, zero key and a nonzero key
        send_light_cmd(light_cmd(OP_ALLOC, 16'h0000, 5'd0, 32'd0, 16'd0, 16'h7FFF, 16'hFFFF,
                                 32'hFFFF_FFFF));
        send_light_cmd(light_cmd(OP_ALLOC, 16'h0007, 5'd0, 32'd0, 16'd0, 16'd100, 16'd2,
                                 32'd50));
        send_light_cmd(light_cmd(OP_ALLOC, 16'h1234, 5'd0, 32'd1, 16'd0, 16'h8000, 16'd1,
                                 32'd1000));
        send_light_cmd(light_cmd(OP_ALLOC, 16'h1234, 5'd0, 32'd5, 16'd0, -16'sd300, 16'd3,
                                 32'd2000));
        send_light_cmd(light_cmd(OP_ALLOC, 16'hFFFF, 5'd0, 32'd3, 16'd0, 16'd1, 16'hFFFF,
                                 32'hFFFF_FFFF));
        send_light_cmd(light_cmd(OP_ALLOC, 16'h0000, 5'd0, 32'd3, 16'd0, 16'h7FFF, 16'd0,
                                 32'd9));
        send_light_cmd(light_cmd(OP_DECAY, 16'h0000, 5'd0, 32'd0, 16'd0, 16'h0000, 16'h0000,
                                 32'd0));
        send_light_cmd(light_cmd(OP_DECAY, 16'h0000, 5'd0, 32'd0, 16'd10, 16'h0000, 16'h0000,
                                 32'd0));
        send_light_cmd(light_cmd(OP_DECAY, 16'hFFFF, 5'd0, 32'd0, 16'hFFFF, 16'h0000,
                                 16'h0000, 32'd0));
        send_light_cmd(light_cmd(OP_ALLOC, 16'hAAAA, 5'd0, 32'd0, 16'd0, 16'h8000, 16'hFFFF,
                                 32'd100));
        // expired slots keep their radius through a tick
        send_light_cmd(light_cmd(OP_DECAY, 16'h0000, 5'd0, 32'd200, 16'hFFFF, 16'h0000,
                                 16'h0000, 32'd0));
        send_light_cmd(light_cmd(OP_READ,  16'h0000, 5'd0, 32'd0, 16'd0, 16'h0000, 16'h0000,
                                 32'd0));
        send_light_cmd(light_cmd(OP_DECAY, 16'h0000, 5'd0, 32'd100, 16'hFFFF, 16'h0000,
                                 16'h0000, 32'd0));
        send_light_cmd(light_cmd(OP_UNUSED, 16'hFFFF, 5'd31, 32'hFFFF_FFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_light_cmd(light_cmd(OP_READ,  16'h0000, 5'd1, 32'd0, 16'd0, 16'h0000, 16'h0000,
                                 32'd0));
        send_light_cmd(light_cmd(OP_READ,  16'h0000, 5'd2, 32'd0, 16'd0, 16'h0000, 16'h0000,
                                 32'd0));
        send_light_cmd(light_cmd(OP_READ,  16'h0000, 5'd3, 32'd0, 16'd0, 16'h0000, 16'h0000,
                                 32'd0));
        send_light_cmd(light_cmd(OP_ALLOC, 16'h5555, 5'd0, 32'hFFFF_FFFF, 16'd0, 16'h5555,
                                 16'h5555, 32'hFFFF_FFFE));
        send_light_cmd(light_cmd(OP_READ,  16'h0000, 5'h15, 32'd0, 16'd0, 16'h0000, 16'h0000,
                                 32'd0));
        send_light_cmd(light_cmd(OP_READ,  16'h0000, 5'h0A, 32'd0, 16'd0, 16'h0000, 16'h0000,
                                 32'd0));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_light_cmd(random_light_cmd());
    endtask

    // Hold the result side off while the sender keeps offering transactions.
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        repeat (8) send_light_cmd(random_light_cmd());
    endtask

    task automatic test_pause_until_drained();
        repeat (3) begin
            repeat (10) send_light_cmd(random_light_cmd());
            wait_for_reports();
        end
    endtask

    task automatic test_no_idle_stretch();
        calm = 1'b1;
        repeat (100) send_light_cmd(random_light_cmd());
        calm = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < LIGHTS; i++) begin
            tbl_key[i]    = '0;
            tbl_expiry[i] = '0;
            tbl_radius[i] = '0;
            tbl_decay[i]  = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(300);
        test_output_backpressure();
        test_pause_until_drained();
        test_no_idle_stretch();
        test_random_traffic(400);

        wait_for_reports();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/kest_pkg.sv
rtl/kest_ram.sv
rtl/keyed_expiring_slot_table_top.sv
tb/tb.sv
